/* rtl/evad_pkg.sv */
package evad_pkg;

    localparam int REQ_W     = 2;
    localparam int SAMPLE_W  = 16;
    localparam int MS_W      = 10;
    localparam int DEC_W     = 2;
    localparam int FORMAT_W  = 1;
    localparam int LEVEL_W   = 31;
    localparam int RUN_W     = 16;
    localparam int SILENCE_W = 20;
    localparam int SQ_W      = 31;
    localparam int ENERGY_W  = 48;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam int MAX_BUFFER_SAMPLES_DEF = 4096;
    localparam int QUEUE_DEPTH            = 2;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISARM = 2'd2;

    localparam logic [DEC_W-1:0] DEC_NONE   = 2'd0;
    localparam logic [DEC_W-1:0] DEC_STOP   = 2'd1;
    localparam logic [DEC_W-1:0] DEC_CANCEL = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FORMAT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RUN     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SILENCE = 2'd3;

    localparam logic [FORMAT_W-1:0]  FORMAT_RST  = 1'b0;
    localparam logic [LEVEL_W-1:0]   LEVEL_RST   = 31'd107374;
    localparam logic [RUN_W-1:0]     RUN_RST     = 16'd200;
    localparam logic [SILENCE_W-1:0] SILENCE_RST = 20'd7000;

    typedef struct packed {
        logic [FORMAT_W-1:0]  fmt;
        logic [LEVEL_W-1:0]   level;
        logic [RUN_W-1:0]     run_ms;
        logic [SILENCE_W-1:0] silence_ms;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [SQ_W-1:0]  sq;
        logic             last;
        logic [MS_W-1:0]  ms;
    } cmd_t;

    typedef struct packed {
        logic [DEC_W-1:0] decision;
        logic             heard;
        logic             armed;
    } res_t;

endpackage

/* rtl/evad_queue.sv */
module evad_queue
    import evad_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/evad_front.sv */
module evad_front
    import evad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                push,
    output logic                full,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [SAMPLE_W-1:0] sample_bits,
    input  logic                buffer_last,
    input  logic [MS_W-1:0]     buffer_ms,
    output logic                cmd_push,
    output cmd_t                cmd_data,
    input  logic                cmd_full
);

    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    cmd_t                 stage_reg;
    cmd_t                 stage_next;
    logic                 advance;
    logic                 accept;
    logic [SAMPLE_W-1:0]  mag16;
    logic [7:0]           mag8;
    logic [SAMPLE_W-1:0]  mag;
    logic [2*SAMPLE_W-1:0] sq_full;

    assign advance  = !stage_valid_reg || !cmd_full;
    assign full     = !advance;
    assign accept   = push && advance;
    assign cmd_push = stage_valid_reg;
    assign cmd_data = stage_reg;

    // square the sample magnitude in Q1.15
    always_comb
    begin
        mag16   = sample_bits[SAMPLE_W-1] ? (~sample_bits + SAMPLE_W'(1)) : sample_bits;
        mag8    = sample_bits[7] ? {1'b0, sample_bits[6:0]} : (8'd128 - sample_bits[7:0]);
        mag     = cfg.fmt[0] ? {mag8, 8'h00} : mag16;
        sq_full = mag * mag;

        stage_next.req  = req_type;
        stage_next.sq   = sq_full[SQ_W-1:0];
        stage_next.last = buffer_last;
        stage_next.ms   = buffer_ms;

        stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

/* rtl/evad_back.sv */
module evad_back
    import evad_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = MAX_BUFFER_SAMPLES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_empty,
    input  cmd_t cmd_data,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res_data
);

    localparam int TALLY_W = $clog2(MAX_BUFFER_SAMPLES + 1);
    localparam int PROD_W  = LEVEL_W + TALLY_W;
    localparam int CMP_W   = ((PROD_W > ENERGY_W) ? PROD_W : ENERGY_W) + 1;

    logic                 active_reg;
    logic                 active_next;
    logic                 heard_reg;
    logic                 heard_next;
    logic [SILENCE_W-1:0] quiet_reg;
    logic [SILENCE_W-1:0] quiet_next;
    logic [RUN_W-1:0]     loud_reg;
    logic [RUN_W-1:0]     loud_next;
    logic [ENERGY_W-1:0]  energy_reg;
    logic [ENERGY_W-1:0]  energy_next;
    logic [TALLY_W-1:0]   tally_reg;
    logic [TALLY_W-1:0]   tally_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;

    logic                 is_sample;
    logic                 inc;
    logic [ENERGY_W-1:0]  energy_acc;
    logic [CMP_W-1:0]     limit;
    logic                 loud;
    logic [RUN_W:0]       loud_sum;
    logic [RUN_W-1:0]     loud_sat;
    logic                 loud_hit;
    logic [SILENCE_W:0]   quiet_sum;
    logic [SILENCE_W-1:0] quiet_sat;
    logic                 quiet_hit;
    logic [DEC_W-1:0]     decision;

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;

    always_comb
    begin
        is_sample  = (cmd_data.req == REQ_SAMPLE) && active_reg;
        inc        = is_sample && (tally_reg < TALLY_W'(MAX_BUFFER_SAMPLES));
        energy_acc = energy_reg + (inc ? ENERGY_W'(cmd_data.sq) : '0);
        // level * tally after this sample, from the product of the tally before it
        limit      = CMP_W'(prod_reg) + (inc ? CMP_W'(cfg.level) : '0);
        loud       = (CMP_W'(energy_acc) >= limit);

        loud_sum   = {1'b0, loud_reg} + (RUN_W + 1)'(cmd_data.ms);
        loud_sat   = loud_sum[RUN_W] ? '1 : loud_sum[RUN_W-1:0];
        loud_hit   = (loud_sat >= cfg.run_ms);
        quiet_sum  = {1'b0, quiet_reg} + (SILENCE_W + 1)'(cmd_data.ms);
        quiet_sat  = quiet_sum[SILENCE_W] ? '1 : quiet_sum[SILENCE_W-1:0];
        quiet_hit  = (quiet_sat >= cfg.silence_ms);

        active_next = active_reg;
        heard_next  = heard_reg;
        quiet_next  = quiet_reg;
        loud_next   = loud_reg;
        energy_next = energy_reg;
        tally_next  = tally_reg;
        decision    = DEC_NONE;

        if (cmd_pop)
        begin
            unique case (cmd_data.req)
                REQ_ARM:
                begin
                    if (!active_reg)
                    begin
                        heard_next  = 1'b0;
                        quiet_next  = '0;
                        loud_next   = '0;
                        energy_next = '0;
                        tally_next  = '0;
                        active_next = 1'b1;
                    end
                end
                REQ_DISARM:
                begin
                    active_next = 1'b0;
                    energy_next = '0;
                    tally_next  = '0;
                end
                REQ_SAMPLE:
                begin
                    if (active_reg)
                    begin
                        if (inc)
                        begin
                            energy_next = energy_acc;
                            tally_next  = tally_reg + TALLY_W'(1);
                        end
                        if (cmd_data.last)
                        begin
                            energy_next = '0;
                            tally_next  = '0;
                            if (loud && loud_hit)
                            begin
                                loud_next  = loud_sat;
                                heard_next = 1'b1;
                                quiet_next = '0;
                            end
                            else
                            begin
                                loud_next  = loud ? loud_sat : '0;
                                quiet_next = quiet_sat;
                                if (quiet_hit)
                                begin
                                    active_next = 1'b0;
                                    decision    = heard_reg ? DEC_STOP : DEC_CANCEL;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        prod_next = PROD_W'(cfg.level) * PROD_W'(tally_next);

        res_data.decision = decision;
        res_data.heard    = heard_next;
        res_data.armed    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            heard_reg  <= 1'b0;
            quiet_reg  <= '0;
            loud_reg   <= '0;
            energy_reg <= '0;
            tally_reg  <= '0;
            prod_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            heard_reg  <= heard_next;
            quiet_reg  <= quiet_next;
            loud_reg   <= loud_next;
            energy_reg <= energy_next;
            tally_reg  <= tally_next;
            prod_reg   <= prod_next;
        end
    end

endmodule

/* rtl/energy_voice_activity_autostop_top.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | push / full          | req_type, sample_bits, buffer_last, buffer_ms
// result   | pop / empty          | decision, speech_heard, armed
// config   | psel/penable/pwrite  | paddr, pwdata, prdata; pready tied high
//
// One item per cycle unless stalled; the front squares the sample (16x16 multiplier),
// the back updates the state with one 49-bit compare against a registered level*tally.
// A result passes the front stage register, the command queue and the result queue.
// Reset clears all control state; the configuration registers take their defaults.
// Stalled results fill both two-entry queues and the front stage, then raise full.
module energy_voice_activity_autostop_top
    import evad_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = MAX_BUFFER_SAMPLES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [SAMPLE_W-1:0] sample_bits,
    input  logic                buffer_last,
    input  logic [MS_W-1:0]     buffer_ms,
    output logic                empty,
    input  logic                pop,
    output logic [DEC_W-1:0]    decision,
    output logic                speech_heard,
    output logic                armed
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_empty;
    logic res_push;
    res_t res_in;
    logic res_full;
    res_t res_out;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            REG_FORMAT:
            begin
                prdata = DATA_W'(cfg_reg.fmt);
                if (cfg_we)
                begin
                    cfg_next.fmt = pwdata[FORMAT_W-1:0];
                end
            end
            REG_LEVEL:
            begin
                prdata = DATA_W'(cfg_reg.level);
                if (cfg_we)
                begin
                    cfg_next.level = pwdata[LEVEL_W-1:0];
                end
            end
            REG_RUN:
            begin
                prdata = DATA_W'(cfg_reg.run_ms);
                if (cfg_we)
                begin
                    cfg_next.run_ms = pwdata[RUN_W-1:0];
                end
            end
            REG_SILENCE:
            begin
                prdata = DATA_W'(cfg_reg.silence_ms);
                if (cfg_we)
                begin
                    cfg_next.silence_ms = pwdata[SILENCE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt        <= FORMAT_RST;
            cfg_reg.level      <= LEVEL_RST;
            cfg_reg.run_ms     <= RUN_RST;
            cfg_reg.silence_ms <= SILENCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    evad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .sample_bits (sample_bits),
        .buffer_last (buffer_last),
        .buffer_ms   (buffer_ms),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .cmd_full    (cmd_full)
    );

    evad_queue #(
        .W     ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    evad_back #(
        .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    evad_queue #(
        .W     ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign decision     = res_out.decision;
    assign speech_heard = res_out.heard;
    assign armed        = res_out.armed;

    a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && decision != DEC_NONE) |-> !armed)
        else $error("take end result still armed");

    a_stop_heard: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && decision == DEC_STOP) |-> speech_heard)
        else $error("stop without speech heard");

    a_cancel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && decision == DEC_CANCEL) |-> !speech_heard)
        else $error("cancel with speech heard");

endmodule
